@@ design/hti_pkg.sv @@
// ----------------------------------------------------------------------------
// hti_pkg
// Shared constants and codes of the heightmap triangle interpolator.
// ----------------------------------------------------------------------------
package hti_pkg;

	localparam int GRID_SIZE_DEF = 256;

	localparam int COORD_W  = 24;  // Q16.8 world coordinate
	localparam int SCALE_W  = 16;  // Q8.8 spacing and vertical scale
	localparam int HEIGHT_W = 8;
	localparam int CELL_W   = 8;
	localparam int AREA_W   = 2 * SCALE_W;          // product of the two spacings
	localparam int NUM_W    = AREA_W + HEIGHT_W;    // weighted height sum
	localparam int SCALED_W = NUM_W + SCALE_W;      // sum times vertical scale
	localparam int CFG_IDX_W = 2;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE_X = 2'd0,
		CFG_SCALE_Y = 2'd1,
		CFG_SCALE_Z = 2'd2,
		CFG_UNUSED  = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	// item fields that ride along the coordinate division
	typedef struct packed {
		logic [HEIGHT_W-1:0] height_value;
		logic [CELL_W-1:0]   cell_row;
		logic [CELL_W-1:0]   cell_col;
	} wr_side_t;

endpackage

@@ design/hti_div.sv @@
// ----------------------------------------------------------------------------
// hti_div
// Pipelined restoring divider, one quotient bit per stage. The caller keeps
// the top DW bits of the dividend below the divisor.
// ----------------------------------------------------------------------------
module hti_div #(
	parameter int QW = 24,
	parameter int DW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [QW+DW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [DW-1:0] rem,
	output logic [SW-1:0] side_out
);

	logic          vld_s  [QW];
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] bits_s [QW];
	logic [DW-1:0] den_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          v_in;
		logic [DW-1:0] r_in;
		logic [QW-1:0] b_in;
		logic [DW-1:0] d_in;
		logic [SW-1:0] s_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = num[QW+DW-1:QW];
			assign b_in = num[QW-1:0];
			assign d_in = den;
			assign s_in = side_in;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign r_in = rem_s[k-1];
			assign b_in = bits_s[k-1];
			assign d_in = den_s[k-1];
			assign s_in = side_s[k-1];
		end

		// shift in the next dividend bit, subtract when it fits
		assign trial = {r_in, b_in[QW-1]};
		assign diff  = trial - {1'b0, d_in};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				bits_s[k] <= {b_in[QW-2:0], ge};
				den_s[k]  <= d_in;
				side_s[k] <= s_in;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quo       = bits_s[QW-1];
	assign rem       = rem_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

@@ design/hti_mem.sv @@
// ----------------------------------------------------------------------------
// hti_mem
// Height grid storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module hti_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [hti_pkg::HEIGHT_W-1:0] wdata,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [hti_pkg::HEIGHT_W-1:0] rdata0,
	output logic [hti_pkg::HEIGHT_W-1:0] rdata1
);

	logic [hti_pkg::HEIGHT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

@@ design/heightmap_triangle_interpolator.sv @@
// ----------------------------------------------------------------------------
// heightmap_triangle_interpolator
// Height grid with triangle interpolation of queries in fixed point.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  s_axis   in   tvalid/tready         tdata: col,row,height,x,z  tuser: func
//  m_axis   out  tvalid/tready         tdata: height_out          tuser: oor
//  cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  One item per cycle while the output register is not stalled; a query result
//  runs through the 24-stage dividers of the coordinate split and the final normalization.
//  Writes update the grid at the read stage, so program order holds.
//  No clearing pass: grid entries read before being written are undefined.
//  The whole pipeline advances unless a result sits in the output register
//  unaccepted; cfg_ready is always high.
// ----------------------------------------------------------------------------
module heightmap_triangle_interpolator #(
	parameter int GRID_SIZE = hti_pkg::GRID_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // cell_col, cell_row, height_value, query_x, query_z
	input  logic [0:0]  s_axis_tuser,   // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // height_out
	output logic [0:0]  m_axis_tuser,   // out_of_range
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [hti_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hti_pkg::SCALE_W-1:0]   cfg_data
);

	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = hti_pkg::COORD_W;
	localparam int SW    = hti_pkg::SCALE_W;
	localparam int HW    = hti_pkg::HEIGHT_W;
	localparam int PW    = hti_pkg::AREA_W;
	localparam int NW    = hti_pkg::NUM_W;
	localparam int XW    = hti_pkg::SCALED_W;

	logic en;

	// ---------------- configuration ----------------
	logic [SW-1:0] scale_x_q, scale_y_q, scale_z_q;
	logic [SW-1:0] sx, sy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= hti_pkg::SCALE_RESET;
			scale_y_q <= hti_pkg::SCALE_RESET;
			scale_z_q <= hti_pkg::SCALE_RESET;
		end else if (cfg_valid) begin
			unique case (hti_pkg::cfg_idx_t'(cfg_index))
				hti_pkg::CFG_SCALE_X: scale_x_q <= cfg_data;
				hti_pkg::CFG_SCALE_Y: scale_y_q <= cfg_data;
				hti_pkg::CFG_SCALE_Z: scale_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero spacing acts as the smallest step (1/256)
	assign sx = (scale_x_q == '0) ? SW'(1) : scale_x_q;
	assign sy = (scale_y_q == '0) ? SW'(1) : scale_y_q;

	assign s_axis_tready = en;

	// ---------------- coordinate division ----------------
	hti_pkg::wr_side_t side_in, side_out;
	logic          vx, vz, dv;
	logic [CW-1:0] cx, cz;
	logic [SW-1:0] rx, rz;
	logic [0:0]    func_d;

	assign side_in.cell_col     = s_axis_tdata[7:0];
	assign side_in.cell_row     = s_axis_tdata[15:8];
	assign side_in.height_value = s_axis_tdata[23:16];

	hti_div #(.QW(CW), .DW(SW), .SW(1)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_axis_tvalid),
		.num({{SW{1'b0}}, s_axis_tdata[47:24]}),
		.den(sx),
		.side_in(s_axis_tuser),
		.out_valid(vx), .quo(cx), .rem(rx), .side_out(func_d)
	);

	hti_div #(.QW(CW), .DW(SW), .SW($bits(hti_pkg::wr_side_t))) u_div_z (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_axis_tvalid),
		.num({{SW{1'b0}}, s_axis_tdata[71:48]}),
		.den(sy),
		.side_in(side_in),
		.out_valid(vz), .quo(cz), .rem(rz), .side_out(side_out)
	);

	assign dv = vx & vz;

	// ---------------- grid access ----------------
	logic          is_query, is_write, oor, in_grid, we;
	logic [31:0]   base32, waddr32;
	logic [AW-1:0] ra_h1, ra_h2, ra_h3, ra_h4, waddr;
	logic [HW-1:0] h1, h2, h3, h4;

	assign is_query = (hti_pkg::func_t'(func_d) == hti_pkg::FUNC_QUERY);
	assign is_write = (hti_pkg::func_t'(func_d) == hti_pkg::FUNC_WRITE);
	assign oor = (32'(cx) >= 32'(GRID_SIZE - 1)) || (32'(cz) >= 32'(GRID_SIZE - 1));
	assign in_grid = (32'(side_out.cell_col) < 32'(GRID_SIZE))
		&& (32'(side_out.cell_row) < 32'(GRID_SIZE));
	assign we = en && dv && is_write && in_grid;

	assign base32  = 32'(cz) * 32'(GRID_SIZE) + 32'(cx);
	assign waddr32 = 32'(side_out.cell_row) * 32'(GRID_SIZE) + 32'(side_out.cell_col);
	assign ra_h1 = base32[AW-1:0];
	assign ra_h2 = AW'(base32 + 32'd1);
	assign ra_h3 = AW'(base32 + 32'(GRID_SIZE));
	assign ra_h4 = AW'(base32 + 32'(GRID_SIZE) + 32'd1);
	assign waddr = waddr32[AW-1:0];

	hti_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_lo (
		.clk(clk), .en(en), .we(we), .waddr(waddr), .wdata(side_out.height_value),
		.raddr0(ra_h1), .raddr1(ra_h2), .rdata0(h1), .rdata1(h2)
	);

	hti_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_hi (
		.clk(clk), .en(en), .we(we), .waddr(waddr), .wdata(side_out.height_value),
		.raddr0(ra_h3), .raddr1(ra_h4), .rdata0(h3), .rdata1(h4)
	);

	// ---------------- stage 1: barycentric terms ----------------
	logic          vld_s1, oor_s1;
	logic [PW-1:0] a_s1, b_s1, p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= dv && is_query;  // drop writes here
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s1 <= oor;
			a_s1   <= PW'(rx) * PW'(sy);
			b_s1   <= PW'(rz) * PW'(sx);
			p_s1   <= PW'(sx) * PW'(sy);
		end
	end

	// ---------------- stage 2: triangle select, weights ----------------
	logic          vld_s2, oor_s2;
	logic [PW-1:0] wa_s2, wb_s2, wc_s2, p_s2;
	logic [HW-1:0] ha_s2, hb_s2, hc_s2;
	logic [PW:0]   ab_sum;
	logic          upper;

	assign ab_sum = {1'b0, a_s1} + {1'b0, b_s1};
	assign upper  = ab_sum >= {1'b0, p_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s2 <= oor_s1;
			p_s2   <= p_s1;
			wa_s2  <= upper ? PW'(ab_sum - {1'b0, p_s1}) : PW'({1'b0, p_s1} - ab_sum);
			wb_s2  <= upper ? (p_s1 - b_s1) : a_s1;
			wc_s2  <= upper ? (p_s1 - a_s1) : b_s1;
			ha_s2  <= upper ? h4 : h1;
			hb_s2  <= h2;
			hc_s2  <= h3;
		end
	end

	// ---------------- stage 3: weighted corners ----------------
	logic          vld_s3, oor_s3;
	logic [PW-1:0] p_s3;
	logic [NW-1:0] ta_s3, tb_s3, tc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s3 <= oor_s2;
			p_s3   <= p_s2;
			ta_s3  <= NW'(wa_s2) * NW'(ha_s2);
			tb_s3  <= NW'(wb_s2) * NW'(hb_s2);
			tc_s3  <= NW'(wc_s2) * NW'(hc_s2);
		end
	end

	// ---------------- stage 4: sum ----------------
	logic          vld_s4, oor_s4;
	logic [PW-1:0] p_s4;
	logic [NW-1:0] num_s4;
	logic [NW+1:0] tsum;

	// sum never exceeds 255 times the cell area
	assign tsum = (NW+2)'(ta_s3) + (NW+2)'(tb_s3) + (NW+2)'(tc_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s4 <= oor_s3;
			p_s4   <= p_s3;
			num_s4 <= tsum[NW-1:0];
		end
	end

	// ---------------- stage 5: vertical scale ----------------
	logic          vld_s5, oor_s5;
	logic [PW-1:0] p_s5;
	logic [XW-1:0] scaled_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s5    <= oor_s4;
			p_s5      <= p_s4;
			scaled_s5 <= XW'(num_s4) * XW'(scale_z_q);
		end
	end

	// ---------------- normalize by cell area ----------------
	// quotient is bounded by 255 * scale_z, so it never exceeds 24 bits
	logic          fv;
	logic [CW-1:0] fq;
	logic [PW-1:0] frem;
	logic [0:0]    foor;

	hti_div #(.QW(CW), .DW(PW), .SW(1)) u_div_norm (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s5),
		.num(scaled_s5),
		.den(p_s5),
		.side_in(oor_s5),
		.out_valid(fv), .quo(fq), .rem(frem), .side_out(foor)
	);

	// ---------------- output register ----------------
	logic          out_vld_q;
	logic [CW-1:0] out_height_q;
	logic          out_oor_q;

	assign en = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= fv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_oor_q    <= foor[0];
			out_height_q <= (foor[0] || (frem == '1 && 1'b0)) ? '0 : fq;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_height_q;
	assign m_axis_tuser  = out_oor_q;

endmodule

@@ design/hti_checker.sv @@
// ----------------------------------------------------------------------------
// hti_checker
// Port-level checks of the heightmap triangle interpolator.
// ----------------------------------------------------------------------------
module hti_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [71:0] s_axis_tdata,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [hti_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [hti_pkg::SCALE_W-1:0]   cfg_data
);

	// an off-grid query reports zero height
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 24'd0)
		else $error("off-grid result carries nonzero height");

	// interpolation never exceeds the top height times the largest scale
	a_height_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata <= 24'd16711425)
		else $error("height exceeds bound");

	// input side stalls only behind a waiting result
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind heightmap_triangle_interpolator hti_checker u_hti_checker (.*);
